// ===== src/clpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package clpt_pkg;

  localparam int ENTRIES     = 8192;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int HIST_SLOTS  = 4;
  localparam int CONF_BITS   = 4;
  localparam int CONF_W      = CONF_BITS + 1;
  localparam int LVL_W       = 2;
  localparam int CODE_W      = 3;
  localparam int PC_W        = 48;

  localparam logic [CONF_W-1:0] CONF_TOP  = CONF_W'(1 << CONF_BITS);
  localparam logic [CONF_W-1:0] CONF_INIT = CONF_W'(1 << (CONF_BITS - 1));

  // level codes
  localparam logic [LVL_W-1:0]  LVL_L1      = 2'd0;
  localparam logic [LVL_W-1:0]  LVL_DRAM    = 2'd3;
  localparam logic [CODE_W-1:0] CODE_DRAM   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_L1     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_L1_MARK = 3'd4;

  // mode register values; the unused code behaves as the tournament
  localparam logic [1:0] MODE_GREEDY = 2'd0;
  localparam logic [1:0] MODE_HYST   = 2'd1;
  localparam logic [1:0] MODE_TOURN  = 2'd2;

  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  localparam logic WHO_GREEDY = 1'b0;
  localparam logic WHO_HYST   = 1'b1;

  typedef struct packed {
    logic [CONF_W-1:0]                  hyst_conf;
    logic [CONF_W-1:0]                  greedy_conf;
    logic [1:0][CODE_W-1:0]             hyst_codes;
    logic [HIST_SLOTS-1:0][LVL_W-1:0]   history;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             who;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  function automatic entry_t entry_init();
    entry_t e;
    for (int k = 0; k < HIST_SLOTS; k++) begin
      e.history[k] = LVL_DRAM;
    end
    e.hyst_codes[0] = CODE_DRAM;
    e.hyst_codes[1] = CODE_DRAM;
    e.greedy_conf   = CONF_INIT;
    e.hyst_conf     = CONF_INIT;
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== src/clpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module clpt_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/clpt_entry_logic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module clpt_entry_logic
  import clpt_pkg::*;
(
  input  wire entry_t            rd_entry,
  input  wire logic [1:0]        mode,
  input  wire logic [LVL_W-1:0]  actual,
  output result_t                result,
  output entry_t                 wr_entry
);

  logic [LVL_W-1:0]  greedy_lvl;
  logic [LVL_W-1:0]  hyst_lvl;
  logic [CODE_W-1:0] code_a;
  logic [CODE_W-1:0] code_b;
  logic [CODE_W-1:0] code_max;
  logic [CODE_W-1:0] actual_code;

  // greedy guess: largest level in the history
  always_comb begin
    greedy_lvl = LVL_L1;
    for (int k = 0; k < HIST_SLOTS; k++) begin
      if (rd_entry.history[k] > greedy_lvl) begin
        greedy_lvl = rd_entry.history[k];
      end
    end
  end

  // hysteresis guess: L1 on a marker, else the larger of the two
  assign code_a   = rd_entry.hyst_codes[0];
  assign code_b   = rd_entry.hyst_codes[1];
  assign code_max = (code_a > code_b) ? code_a : code_b;
  always_comb begin
    if (code_a == CODE_L1_MARK || code_b == CODE_L1_MARK) begin
      hyst_lvl = LVL_L1;
    end else begin
      hyst_lvl = code_max[LVL_W-1:0];
    end
  end

  always_comb begin
    case (mode)
      MODE_GREEDY: begin
        result.level = greedy_lvl;
        result.who   = WHO_GREEDY;
      end
      MODE_HYST: begin
        result.level = hyst_lvl;
        result.who   = WHO_HYST;
      end
      default: begin
        if (rd_entry.greedy_conf >= rd_entry.hyst_conf) begin
          result.level = greedy_lvl;
          result.who   = WHO_GREEDY;
        end else begin
          result.level = hyst_lvl;
          result.who   = WHO_HYST;
        end
      end
    endcase
  end

  assign actual_code = {1'b0, actual};

  // trained entry
  always_comb begin
    wr_entry = rd_entry;
    for (int k = 0; k < HIST_SLOTS - 1; k++) begin
      wr_entry.history[k] = rd_entry.history[k+1];
    end
    wr_entry.history[HIST_SLOTS-1] = actual;

    if (actual != LVL_L1 || (code_b != CODE_L1_MARK && code_a != CODE_L1)) begin
      wr_entry.hyst_codes[1] = code_a;
      wr_entry.hyst_codes[0] = actual_code;
    end else begin
      wr_entry.hyst_codes[0] = CODE_L1_MARK;
    end

    if (greedy_lvl == actual) begin
      if (rd_entry.greedy_conf < CONF_TOP) begin
        wr_entry.greedy_conf = rd_entry.greedy_conf + CONF_W'(1);
      end
    end else if (rd_entry.greedy_conf != '0) begin
      wr_entry.greedy_conf = rd_entry.greedy_conf - CONF_W'(1);
    end

    if (hyst_lvl == actual) begin
      if (rd_entry.hyst_conf < CONF_TOP) begin
        wr_entry.hyst_conf = rd_entry.hyst_conf + CONF_W'(1);
      end
    end else if (rd_entry.hyst_conf != '0) begin
      wr_entry.hyst_conf = rd_entry.hyst_conf - CONF_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== src/cache_level_tournament_predictor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | ports                          | contents (low bit up)
// ---------+--------------------------------+---------------------------------------
// in       | in_tvalid/in_tready            | tdata: load_pc[47:0], seen_level[49:48]
//          |                                | tuser: func (0 predict, 1 update)
// out      | out_tvalid/out_tready          | tdata: guess_level[1:0]
//          |                                | tuser: chosen_predictor
// cfg      | cfg_psel/penable/pwrite/paddr  | register 0 at byte 0: mode[1:0]
//
// On accept the table read is issued; in ST_LOOKUP the entry is evaluated,
// written back for an update and loaded into the output register, once that
// register is free. in_tready stays low while an item is evaluated and written
// back, so the next read always sees the trained entry.
// After reset a clearing pass writes all 8192 entries, one per cycle, with
// in_tready low; configuration writes are taken meanwhile.
// A stalled output holds the finished lookup; a new item is taken while the
// previous result still waits in the output register.
module cache_level_tournament_predictor_top
  import clpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,    // load_pc[47:0], seen_level[49:48], zeros
  input  wire logic        in_tuser,    // func

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // guess_level[1:0], zeros
  output logic             out_tuser,   // chosen_predictor

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic REG_MODE_WORD = 1'b0;

  state_t            state_r, state_nxt;
  logic [1:0]        mode_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic [IDX_W-1:0]  idx_r;
  logic              func_r;
  logic [LVL_W-1:0]  actual_r;
  logic              out_valid_r;
  logic [LVL_W-1:0]  out_level_r;
  logic              out_who_r;

  logic              accept;
  logic              finish;
  logic              clr_done;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            upd_entry;
  result_t           result;
  logic              cfg_write;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODE_WORD) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TOURN;
    end else if (cfg_write && cfg_paddr[2] == REG_MODE_WORD) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  // entry table, read at accept, written back in ST_LOOKUP on finish for updates
  clpt_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .re    (accept),
    .raddr (in_tdata[IDX_W-1:0]),
    .rdata (ram_rdata),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  clpt_entry_logic u_entry (
    .rd_entry (entry_t'(ram_rdata)),
    .mode     (mode_r),
    .actual   (actual_r),
    .result   (result),
    .wr_entry (upd_entry)
  );

  assign clr_done = (clr_idx_r == IDX_W'(ENTRIES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    finish    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ENTRY_W'(upd_entry);
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = ENTRY_W'(entry_init());
      end
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_LOOKUP: begin
        finish = !out_valid_r || out_tready;
        ram_we = finish && (func_r == FUNC_UPDATE);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
    end
  end

  // hold the item's index and update fields for the write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= in_tdata[IDX_W-1:0];
      actual_r <= in_tdata[PC_W+LVL_W-1:PC_W];
      func_r   <= in_tuser;
    end
  end

  // output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_level_r <= result.level;
      out_who_r   <= result.who;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_level_r};
  assign out_tuser  = out_who_r;

endmodule
`default_nettype wire
